// ===== rtl/core/rbs_pkg.sv =====
`default_nettype none
package rbs_pkg;

   localparam int WORD_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int TOL_W      = 16;
   localparam int DIVIDEND_W = WORD_W + 1 + FRAC_W;
   localparam int QUO_W      = WORD_W;
   localparam int DIV_STAGES = QUO_W + 1;
   localparam int TAIL_N     = 6;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int PSH_W      = PROD_W - FRAC_W;
   localparam int SUM_W      = PSH_W + 2;
   localparam int CSR_IDX_W  = 3;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [WORD_W:0]   diff_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam word_type T_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type T_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam word_type BOX_MAX_RESET = word_type'(1) <<< FRAC_W;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Z  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_TOL   = 3'd6;

   typedef enum logic [2:0] {
      FACE_NEG_X = 3'd0,
      FACE_POS_X = 3'd1,
      FACE_NEG_Y = 3'd2,
      FACE_POS_Y = 3'd3,
      FACE_NEG_Z = 3'd4,
      FACE_POS_Z = 3'd5,
      FACE_NONE  = 3'd6
   } face_type;

   function automatic logic [WORD_W:0] mag_diff(diff_type v);
      logic [WORD_W:0] r;
      r = v[WORD_W] ? -v : v;
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] mag_word(word_type v);
      logic [WORD_W-1:0] r;
      r = v[WORD_W-1] ? -v : v;
      return r;
   endfunction

   // signed saturation of a sign-magnitude quotient
   function automatic word_type sat_div(logic neg, logic ovf, logic [QUO_W-1:0] q);
      word_type r;
      if (!neg) begin
         r = (ovf || q[QUO_W-1]) ? T_MAX : word_type'(q);
      end else begin
         r = (ovf || (q[QUO_W-1] && (|q[QUO_W-2:0]))) ? T_MIN : word_type'(-q);
      end
      return r;
   endfunction

   function automatic word_type sat_sum(sum_type s);
      logic in_range;
      word_type r;
      in_range = (&s[SUM_W-1:WORD_W-1]) || !(|s[SUM_W-1:WORD_W-1]);
      if (in_range) begin
         r = s[WORD_W-1:0];
      end else begin
         r = s[SUM_W-1] ? T_MIN : T_MAX;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rbs_if.sv =====
`default_nettype none
interface rbs_req_if import rbs_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type origin_x;
   word_type origin_y;
   word_type origin_z;
   word_type dir_x;
   word_type dir_y;
   word_type dir_z;
   word_type t_lower;
   word_type t_upper;

   modport source (output valid, output origin_x, output origin_y, output origin_z,
                   output dir_x, output dir_y, output dir_z, output t_lower,
                   output t_upper, input ready);
   modport sink   (input valid, input origin_x, input origin_y, input origin_z,
                   input dir_x, input dir_y, input dir_z, input t_lower,
                   input t_upper, output ready);
endinterface

interface rbs_rsp_if import rbs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       hit;
   word_type   hit_distance;
   word_type   impact_x;
   word_type   impact_y;
   word_type   impact_z;
   logic [2:0] face_code;
   logic       front_face;

   modport source (output valid, output hit, output hit_distance, output impact_x,
                   output impact_y, output impact_z, output face_code,
                   output front_face, input ready);
   modport sink   (input valid, input hit, input hit_distance, input impact_x,
                   input impact_y, input impact_z, input face_code,
                   input front_face, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rbs_div_pipe.sv =====
`default_nettype none
module rbs_div_pipe import rbs_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [QUO_W-1:0]      divisor,
   output logic [QUO_W-1:0]      quotient,
   output logic                  overflow
);

   logic [QUO_W-1:0] rem_ff [0:QUO_W];
   logic [QUO_W-1:0] low_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   logic [QUO_W-1:0] dvs_ff [0:QUO_W];
   logic             ovf_ff [0:QUO_W];

   logic [QUO_W-1:0] top_in;
   logic             ovf_in;

   always_comb begin
      top_in = QUO_W'(dividend[DIVIDEND_W-1:QUO_W]);
      // quotient of 2^32 or more saturates anyway
      ovf_in = top_in >= divisor;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= ovf_in;
         rem_ff[0] <= ovf_in ? '0 : top_in;
         low_ff[0] <= dividend[QUO_W-1:0];
         quo_ff[0] <= '0;
         dvs_ff[0] <= divisor;
      end
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_step
      logic [QUO_W:0]   trial;
      logic             take;
      logic [QUO_W:0]   rem_in;

      always_comb begin
         trial  = {rem_ff[j-1], low_ff[j-1][QUO_W-1]};
         take   = trial >= {1'b0, dvs_ff[j-1]};
         rem_in = take ? (trial - {1'b0, dvs_ff[j-1]}) : trial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in[QUO_W-1:0];
            low_ff[j] <= {low_ff[j-1][QUO_W-2:0], 1'b0};
            quo_ff[j] <= {quo_ff[j-1][QUO_W-2:0], take};
            dvs_ff[j] <= dvs_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign quotient = quo_ff[QUO_W];
   assign overflow = ovf_ff[QUO_W];

endmodule
`default_nettype wire

// ===== rtl/core/ray_box_slab_intersect.sv =====
`default_nettype none
// Ray against axis-aligned box, slab method, signed Q16.16. One request is taken every
// cycle while the result side does not stall. Most of the pipeline depth is
// the six slab dividers, each a pipelined restoring divider that settles one quotient
// bit per stage (32 stages plus an overflow stage). A stall on the result side holds the
// whole pipeline in place. Box bounds and face tolerance come from the csr port and must
// only be written while no request is in flight.
module ray_box_slab_intersect import rbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rbs_req_if.sink              req,
   rbs_rsp_if.source            rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   typedef struct packed {
      logic [2:0][WORD_W-1:0] org;
      logic [2:0][WORD_W-1:0] dir;
      logic [WORD_W-1:0]      tlo;
      logic [WORD_W-1:0]      thi;
      logic [2:0]             rej;
      logic [2:0]             zero;
      logic [5:0]             neg;
   } side_type;

   typedef struct packed {
      logic [2:0][WORD_W-1:0] org;
      logic [2:0][WORD_W-1:0] dir;
      logic [WORD_W-1:0]      t;
      logic                   miss;
   } tail_type;

   // configuration
   word_type          box_min_ff [3];
   word_type          box_max_ff [3];
   logic [TOL_W-1:0]  tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            box_min_ff[a] <= '0;
            box_max_ff[a] <= BOX_MAX_RESET;
         end
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_MIN_X: box_min_ff[0] <= csr_wdata;
            CSR_BOX_MIN_Y: box_min_ff[1] <= csr_wdata;
            CSR_BOX_MIN_Z: box_min_ff[2] <= csr_wdata;
            CSR_BOX_MAX_X: box_max_ff[0] <= csr_wdata;
            CSR_BOX_MAX_Y: box_max_ff[1] <= csr_wdata;
            CSR_BOX_MAX_Z: box_max_ff[2] <= csr_wdata;
            CSR_FACE_TOL:  tol_ff        <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic adv;
   logic out_v_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic vd_ff [0:DIV_STAGES-1];
   logic vt_ff [0:TAIL_N-1];

   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k < DIV_STAGES; k++) vd_ff[k] <= 1'b0;
         for (int k = 0; k < TAIL_N; k++) vt_ff[k] <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req.valid;
         v2_ff    <= v1_ff;
         vd_ff[0] <= v2_ff;
         for (int k = 1; k < DIV_STAGES; k++) vd_ff[k] <= vd_ff[k-1];
         v3_ff    <= vd_ff[DIV_STAGES-1];
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         vt_ff[0] <= v6_ff;
         for (int k = 1; k < TAIL_N; k++) vt_ff[k] <= vt_ff[k-1];
         out_v_ff <= vt_ff[TAIL_N-1];
      end
   end

   // stage 1: request capture
   word_type o1_ff [3];
   word_type d1_ff [3];
   word_type tlo1_ff, thi1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         o1_ff[0] <= req.origin_x;
         o1_ff[1] <= req.origin_y;
         o1_ff[2] <= req.origin_z;
         d1_ff[0] <= req.dir_x;
         d1_ff[1] <= req.dir_y;
         d1_ff[2] <= req.dir_z;
         tlo1_ff  <= req.t_lower;
         thi1_ff  <= req.t_upper;
      end
   end

   // stage 2: slab differences and parallel-axis check
   diff_type dlo2_ff [3];
   diff_type dhi2_ff [3];
   word_type o2_ff [3];
   word_type d2_ff [3];
   word_type tlo2_ff, thi2_ff;
   logic [2:0] rej2_ff, zero2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            dlo2_ff[a]  <= {box_min_ff[a][WORD_W-1], box_min_ff[a]}
                           - {o1_ff[a][WORD_W-1], o1_ff[a]};
            dhi2_ff[a]  <= {box_max_ff[a][WORD_W-1], box_max_ff[a]}
                           - {o1_ff[a][WORD_W-1], o1_ff[a]};
            zero2_ff[a] <= d1_ff[a] == '0;
            rej2_ff[a]  <= (d1_ff[a] == '0)
                           && ((o1_ff[a] < box_min_ff[a]) || (o1_ff[a] > box_max_ff[a]));
            o2_ff[a]    <= o1_ff[a];
            d2_ff[a]    <= d1_ff[a];
         end
         tlo2_ff <= tlo1_ff;
         thi2_ff <= thi1_ff;
      end
   end

   // dividers: index 2a is the min bound, 2a+1 the max bound
   logic [DIVIDEND_W-1:0] dvd [6];
   logic [QUO_W-1:0]      dvs [3];
   logic [QUO_W-1:0]      quo [6];
   logic                  ovf [6];
   side_type              side_in;
   side_type              side_ff [0:DIV_STAGES-1];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dvd[2*a]           = {mag_diff(dlo2_ff[a]), {FRAC_W{1'b0}}};
         dvd[2*a+1]         = {mag_diff(dhi2_ff[a]), {FRAC_W{1'b0}}};
         dvs[a]             = mag_word(d2_ff[a]);
         side_in.org[a]     = o2_ff[a];
         side_in.dir[a]     = d2_ff[a];
         side_in.neg[2*a]   = dlo2_ff[a][WORD_W] ^ d2_ff[a][WORD_W-1];
         side_in.neg[2*a+1] = dhi2_ff[a][WORD_W] ^ d2_ff[a][WORD_W-1];
      end
      side_in.tlo  = tlo2_ff;
      side_in.thi  = thi2_ff;
      side_in.rej  = rej2_ff;
      side_in.zero = zero2_ff;
   end

   for (genvar i = 0; i < 6; i++) begin : g_div
      rbs_div_pipe u_div (
         .clock    (clock),
         .en       (adv),
         .dividend (dvd[i]),
         .divisor  (dvs[i/2]),
         .quotient (quo[i]),
         .overflow (ovf[i])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < DIV_STAGES; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // stage 3: saturate the slab distances
   side_type s3_ff, s4_ff, s5_ff;
   word_type ta3_ff [3];
   word_type tb3_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            ta3_ff[a] <= sat_div(side_ff[DIV_STAGES-1].neg[2*a], ovf[2*a], quo[2*a]);
            tb3_ff[a] <= sat_div(side_ff[DIV_STAGES-1].neg[2*a+1], ovf[2*a+1],
                                 quo[2*a+1]);
         end
         s3_ff <= side_ff[DIV_STAGES-1];
      end
   end

   // stage 4: order entry and exit per axis
   word_type tn4_ff [3];
   word_type tf4_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            if (s3_ff.zero[a]) begin
               tn4_ff[a] <= T_MIN;
               tf4_ff[a] <= T_MAX;
            end else if (ta3_ff[a] > tb3_ff[a]) begin
               tn4_ff[a] <= tb3_ff[a];
               tf4_ff[a] <= ta3_ff[a];
            end else begin
               tn4_ff[a] <= ta3_ff[a];
               tf4_ff[a] <= tb3_ff[a];
            end
         end
         s4_ff <= s3_ff;
      end
   end

   // stage 5: latest entry, earliest exit
   word_type tn_in, tf_in;
   word_type tn5_ff, tf5_ff;

   always_comb begin
      tn_in = tn4_ff[0];
      tf_in = tf4_ff[0];
      for (int a = 1; a < 3; a++) begin
         if (tn4_ff[a] > tn_in) tn_in = tn4_ff[a];
         if (tf4_ff[a] < tf_in) tf_in = tf4_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tn5_ff <= tn_in;
         tf5_ff <= tf_in;
         s5_ff  <= s4_ff;
      end
   end

   // stage 6: pick the distance inside the open interval
   logic     in_n, in_f;
   word_type t6_ff;
   logic     miss6_ff;
   side_type s6_ff;

   always_comb begin
      in_n = ($signed(s5_ff.tlo) < tn5_ff) && (tn5_ff < $signed(s5_ff.thi));
      in_f = ($signed(s5_ff.tlo) < tf5_ff) && (tf5_ff < $signed(s5_ff.thi));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t6_ff    <= in_n ? tn5_ff : tf5_ff;
         miss6_ff <= (|s5_ff.rej) || (tn5_ff > tf5_ff) || !(in_n || in_f);
         s6_ff    <= s5_ff;
      end
   end

   // tail stages carry the ray along with the impact math
   tail_type tail_in;
   tail_type tail_ff [0:TAIL_N-1];

   always_comb begin
      tail_in.org  = s6_ff.org;
      tail_in.dir  = s6_ff.dir;
      tail_in.t    = t6_ff;
      tail_in.miss = miss6_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tail_ff[0] <= tail_in;
         for (int k = 1; k < TAIL_N; k++) tail_ff[k] <= tail_ff[k-1];
      end
   end

   // stage 7: magnitudes for the product
   logic [WORD_W-1:0] tmag7_ff;
   logic [WORD_W-1:0] dmag7_ff [3];
   logic [2:0]        sneg7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         tmag7_ff <= mag_word(t6_ff);
         for (int a = 0; a < 3; a++) begin
            dmag7_ff[a] <= mag_word(s6_ff.dir[a]);
            sneg7_ff[a] <= t6_ff[WORD_W-1] ^ s6_ff.dir[a][WORD_W-1];
         end
      end
   end

   // stage 8: t * dir
   logic [PROD_W-1:0] prod8_ff [3];
   logic [2:0]        sneg8_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) prod8_ff[a] <= tmag7_ff * dmag7_ff[a];
         sneg8_ff <= sneg7_ff;
      end
   end

   // stage 9: origin plus truncated product
   sum_type sum9_ff [3];
   sum_type org_ext [3];
   sum_type prd_ext [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         org_ext[a] = {{(SUM_W-WORD_W){tail_ff[1].org[a][WORD_W-1]}}, tail_ff[1].org[a]};
         prd_ext[a] = {{(SUM_W-PSH_W){1'b0}}, prod8_ff[a][PROD_W-1:FRAC_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            sum9_ff[a] <= sneg8_ff[a] ? (org_ext[a] - prd_ext[a]) : (org_ext[a] + prd_ext[a]);
         end
      end
   end

   // stage 10: saturate impact
   word_type imp10_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) imp10_ff[a] <= sat_sum(sum9_ff[a]);
      end
   end

   // stage 11: distance to each face plane
   diff_type dlo11_ff [3];
   diff_type dhi11_ff [3];
   word_type imp11_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            dlo11_ff[a] <= {imp10_ff[a][WORD_W-1], imp10_ff[a]}
                           - {box_min_ff[a][WORD_W-1], box_min_ff[a]};
            dhi11_ff[a] <= {imp10_ff[a][WORD_W-1], imp10_ff[a]}
                           - {box_max_ff[a][WORD_W-1], box_max_ff[a]};
            imp11_ff[a] <= imp10_ff[a];
         end
      end
   end

   // stage 12: face tolerance tests
   logic [5:0] near12_ff;
   word_type   imp12_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            near12_ff[2*a]   <= mag_diff(dlo11_ff[a]) < {{(WORD_W+1-TOL_W){1'b0}}, tol_ff};
            near12_ff[2*a+1] <= mag_diff(dhi11_ff[a]) < {{(WORD_W+1-TOL_W){1'b0}}, tol_ff};
            imp12_ff[a]      <= imp11_ff[a];
         end
      end
   end

   // output register: first matching face wins
   tail_type   tl;
   face_type   face_in;
   logic       front_in;
   logic [2:0] dpos, dneg;

   always_comb begin
      tl = tail_ff[TAIL_N-1];
      for (int a = 0; a < 3; a++) begin
         dneg[a] = tl.dir[a][WORD_W-1];
         dpos[a] = !tl.dir[a][WORD_W-1] && (tl.dir[a] != '0);
      end
      if (near12_ff[0]) begin
         face_in = FACE_NEG_X; front_in = dpos[0];
      end else if (near12_ff[1]) begin
         face_in = FACE_POS_X; front_in = dneg[0];
      end else if (near12_ff[2]) begin
         face_in = FACE_NEG_Y; front_in = dpos[1];
      end else if (near12_ff[3]) begin
         face_in = FACE_POS_Y; front_in = dneg[1];
      end else if (near12_ff[4]) begin
         face_in = FACE_NEG_Z; front_in = dpos[2];
      end else if (near12_ff[5]) begin
         face_in = FACE_POS_Z; front_in = dneg[2];
      end else begin
         face_in = FACE_NONE;  front_in = dneg[1];
      end
   end

   logic       hit_ff, front_ff;
   word_type   dist_ff, ix_ff, iy_ff, iz_ff;
   logic [2:0] face_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff   <= !tl.miss;
         dist_ff  <= tl.miss ? '0 : tl.t;
         ix_ff    <= tl.miss ? '0 : imp12_ff[0];
         iy_ff    <= tl.miss ? '0 : imp12_ff[1];
         iz_ff    <= tl.miss ? '0 : imp12_ff[2];
         face_ff  <= tl.miss ? FACE_NEG_X : face_in;
         front_ff <= !tl.miss && front_in;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.hit          = hit_ff;
   assign rsp.hit_distance = dist_ff;
   assign rsp.impact_x     = ix_ff;
   assign rsp.impact_y     = iy_ff;
   assign rsp.impact_z     = iz_ff;
   assign rsp.face_code    = face_ff;
   assign rsp.front_face   = front_ff;

endmodule
`default_nettype wire

// ===== verif/tb_ray_box_slab_intersect.sv =====
`timescale 1ns / 100ps
module tb_ray_box_slab_intersect;
   import rbs_pkg::*;

   typedef struct {
      word_type origin_x, origin_y, origin_z;
      word_type dir_x, dir_y, dir_z;
      word_type t_lower, t_upper;
   } ray_type;

   typedef struct {
      logic     hit;
      word_type hit_distance;
      word_type impact_x, impact_y, impact_z;
      face_type face_code;
      logic     front_face;
   } box_hit_type;

   localparam longint WORD_HI = 64'sd2147483647;
   localparam int IDLE_LIMIT = 5000;

   class slab_scoreboard;
      longint      box_lo [3];
      longint      box_hi [3];
      longint      face_tol;
      box_hit_type hits_due [$];
      int          errors;

      function new();
         box_lo = '{0, 0, 0};
         box_hi = '{65536, 65536, 65536};
         face_tol = 66;
         errors = 0;
      endfunction

      function bit [63:0] mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      function longint sat_sm(bit neg, bit [63:0] m);
         if (!neg) return (m > WORD_HI) ? WORD_HI : longint'(m);
         if (m > WORD_HI + 1) m = WORD_HI + 1;
         return -longint'(m);
      endfunction

      function bit slab(longint o, longint d, longint lo, longint hi,
                        output longint tn, output longint tf);
         longint a, b, s;
         if (d == 0) begin
            tn = -WORD_HI - 1;
            tf = WORD_HI;
            return !(o < lo || o > hi);
         end
         a = sat_sm((lo - o < 0) != (d < 0), (mag(lo - o) << FRAC_W) / mag(d));
         b = sat_sm((hi - o < 0) != (d < 0), (mag(hi - o) << FRAC_W) / mag(d));
         if (a > b) begin
            s = a; a = b; b = s;
         end
         tn = a;
         tf = b;
         return 1;
      endfunction

      function longint along(longint o, longint d, longint t);
         bit [63:0] p;
         longint s;
         p = (mag(t) * mag(d)) >> FRAC_W;
         s = ((t < 0) != (d < 0)) ? -longint'(p) : longint'(p);
         return sat_sm(o + s < 0, mag(o + s));
      endfunction

      function bit near(longint p, longint b);
         return mag(p - b) < face_tol;
      endfunction

      function box_hit_type trace(ray_type r);
         box_hit_type e;
         longint o [3], d [3], tn [3], tf [3], p [3];
         longint t_in, t_out, t, lo, hi;
         e = '{hit: 0, face_code: FACE_NEG_X, default: '0};
         o = '{r.origin_x, r.origin_y, r.origin_z};
         d = '{r.dir_x, r.dir_y, r.dir_z};
         lo = r.t_lower;
         hi = r.t_upper;
         for (int a = 0; a < 3; a++)
            if (!slab(o[a], d[a], box_lo[a], box_hi[a], tn[a], tf[a])) return e;
         t_in = tn[0];
         t_out = tf[0];
         for (int a = 1; a < 3; a++) begin
            if (tn[a] > t_in) t_in = tn[a];
            if (tf[a] < t_out) t_out = tf[a];
         end
         if (t_in > t_out) return e;
         t = t_in;
         if (!(lo < t && t < hi)) begin
            t = t_out;
            if (!(lo < t && t < hi)) return e;
         end
         for (int a = 0; a < 3; a++) p[a] = along(o[a], d[a], t);
         e.hit = 1;
         e.hit_distance = word_type'(t);
         e.impact_x = word_type'(p[0]);
         e.impact_y = word_type'(p[1]);
         e.impact_z = word_type'(p[2]);
         e.face_code = FACE_NONE;
         e.front_face = d[1] < 0;
         // first face within tolerance wins, -x first
         for (int a = 2; a >= 0; a--) begin
            if (near(p[a], box_hi[a])) begin
               e.face_code = face_type'(2 * a + 1);
               e.front_face = d[a] < 0;
            end
            if (near(p[a], box_lo[a])) begin
               e.face_code = face_type'(2 * a);
               e.front_face = d[a] > 0;
            end
         end
         return e;
      endfunction

      function void note_request(ray_type r);
         hits_due.push_back(trace(r));
      endfunction

      function void check_result(box_hit_type got);
         box_hit_type e;
         if (hits_due.size() == 0) begin
            $display("%0t: unexpected result hit=%0b dist=%h", $time, got.hit,
                     got.hit_distance);
            errors++;
            return;
         end
         e = hits_due.pop_front();
         if (got.hit !== e.hit || got.hit_distance !== e.hit_distance
             || got.impact_x !== e.impact_x || got.impact_y !== e.impact_y
             || got.impact_z !== e.impact_z || got.face_code !== e.face_code
             || got.front_face !== e.front_face) begin
            $display("%0t: mismatch expected hit=%0b t=%h p=%h,%h,%h face=%0d front=%0b",
                     $time, e.hit, e.hit_distance, e.impact_x, e.impact_y, e.impact_z,
                     e.face_code, e.front_face);
            $display("%0t:          actual   hit=%0b t=%h p=%h,%h,%h face=%0d front=%0b",
                     $time, got.hit, got.hit_distance, got.impact_x, got.impact_y,
                     got.impact_z, got.face_code, got.front_face);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0] csr_wdata;

   rbs_req_if req_if ();
   rbs_rsp_if rsp_if ();

   ray_box_slab_intersect u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   slab_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  hold_go = 0;

   // request and result monitors
   always @(posedge clock) begin
      box_hit_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request('{req_if.origin_x, req_if.origin_y, req_if.origin_z,
                              req_if.dir_x, req_if.dir_y, req_if.dir_z,
                              req_if.t_lower, req_if.t_upper});
         if (rsp_if.valid && rsp_if.ready) begin
            got.hit = rsp_if.hit;
            got.hit_distance = rsp_if.hit_distance;
            got.impact_x = rsp_if.impact_x;
            got.impact_y = rsp_if.impact_y;
            got.impact_z = rsp_if.impact_z;
            got.face_code = face_type'(rsp_if.face_code);
            got.front_face = rsp_if.front_face;
            sb.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("ray_box_slab_intersect test failed");
         $finish;
      end
   end

   // receiver: always ready, half, quarter stretches, plus one long hold-off
   initial begin
      int rx_cycle, hold_cnt, seg;
      bit hold_done;
      rx_cycle = 0;
      hold_cnt = 0;
      hold_done = 0;
      rsp_if.ready <= 0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (hold_go && !hold_done) begin
            hold_done = 1;
            hold_cnt = 300;
         end
         seg = (rx_cycle / 200) % 3;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_if.ready <= 0;
         end else if (seg == 0) begin
            rsp_if.ready <= 1;
         end else if (seg == 1) begin
            rsp_if.ready <= $urandom_range(0, 1);
         end else begin
            rsp_if.ready <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   function automatic word_type clamp32(longint v);
      if (v > WORD_HI) return T_MAX;
      if (v < -WORD_HI - 1) return T_MIN;
      return word_type'(v);
   endfunction

   function automatic word_type rnd_word();
      return word_type'($urandom);
   endfunction

   int burst_left = 0;

   task automatic send_ray(ray_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1;
      req_if.origin_x <= r.origin_x;
      req_if.origin_y <= r.origin_y;
      req_if.origin_z <= r.origin_z;
      req_if.dir_x <= r.dir_x;
      req_if.dir_y <= r.dir_y;
      req_if.dir_z <= r.dir_z;
      req_if.t_lower <= r.t_lower;
      req_if.t_upper <= r.t_upper;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 0;
      burst_left = 0;
      @(posedge clock);
      while (sb.hits_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_box(longint lx, longint ly, longint lz,
                           longint hx, longint hy, longint hz, int tol);
      csr_write(CSR_BOX_MIN_X, lx[31:0]);
      csr_write(CSR_BOX_MIN_Y, ly[31:0]);
      csr_write(CSR_BOX_MIN_Z, lz[31:0]);
      csr_write(CSR_BOX_MAX_X, hx[31:0]);
      csr_write(CSR_BOX_MAX_Y, hy[31:0]);
      csr_write(CSR_BOX_MAX_Z, hz[31:0]);
      csr_write(CSR_FACE_TOL, WORD_W'(tol));
      csr_we <= 0;
      sb.box_lo = '{lx, ly, lz};
      sb.box_hi = '{hx, hy, hz};
      sb.face_tol = tol;
   endtask

   // aimed ray: origin around the box, direction toward a point inside it, or zero on some axes
   function automatic ray_type aimed_ray();
      ray_type r;
      longint o [3], d [3], lo, hi, span, tgt;
      for (int a = 0; a < 3; a++) begin
         lo = sb.box_lo[a] < sb.box_hi[a] ? sb.box_lo[a] : sb.box_hi[a];
         hi = sb.box_lo[a] < sb.box_hi[a] ? sb.box_hi[a] : sb.box_lo[a];
         span = hi - lo + 1;
         if (span > 64'sd1 << 30) span = 64'sd1 << 30;
         tgt = lo + longint'($urandom) % span;
         o[a] = clamp32((lo + hi) / 2 + longint'($urandom) % (4 * span + 1) - 2 * span);
         if ($urandom_range(0, 5) == 0) begin
            d[a] = 0;
            if ($urandom_range(0, 1)) o[a] = tgt;
         end else begin
            d[a] = clamp32((tgt - o[a]) >>> $urandom_range(0, 3));
         end
      end
      r.origin_x = word_type'(o[0]);
      r.origin_y = word_type'(o[1]);
      r.origin_z = word_type'(o[2]);
      r.dir_x = word_type'(d[0]);
      r.dir_y = word_type'(d[1]);
      r.dir_z = word_type'(d[2]);
      case ($urandom_range(0, 3))
         0: r.t_lower = 0;
         1: r.t_lower = T_MIN;
         default: r.t_lower = -word_type'($urandom_range(0, 32'h30000));
      endcase
      r.t_upper = $urandom_range(0, 1) ? T_MAX : word_type'($urandom_range(1, 32'h40000));
      if ($urandom_range(0, 19) == 0)
         r.t_upper = r.t_lower - word_type'($urandom_range(0, 3));
      return r;
   endfunction

   function automatic ray_type noise_ray();
      return '{rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
               rnd_word(), rnd_word()};
   endfunction

   task automatic random_rays(int n, bit with_hold);
      for (int i = 0; i < n; i++) begin
         if (with_hold && i == n / 3) hold_go = 1;
         send_ray(($urandom_range(0, 4) == 0) ? noise_ray() : aimed_ray());
      end
      drain();
   endtask

   localparam word_type ONE = 32'sh10000;
   localparam word_type HALF = 32'sh8000;

   initial begin
      reset <= 1;
      csr_we <= 0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid <= 0;
      req_if.origin_x <= '0;
      req_if.origin_y <= '0;
      req_if.origin_z <= '0;
      req_if.dir_x <= '0;
      req_if.dir_y <= '0;
      req_if.dir_z <= '0;
      req_if.t_lower <= '0;
      req_if.t_upper <= '0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // unit box after reset
      send_ray('{-ONE, HALF, HALF, ONE, 0, 0, 0, T_MAX});         // -x face, front
      send_ray('{2 * ONE, HALF, HALF, -ONE, 0, 0, 0, T_MAX});     // +x face
      send_ray('{HALF, -ONE, HALF, 0, ONE, 0, 0, T_MAX});         // -y face
      send_ray('{HALF, HALF, 2 * ONE, 0, 0, -ONE, 0, T_MAX});     // +z face
      send_ray('{HALF, HALF, HALF, 0, ONE, 0, 0, T_MAX});         // inside: exit distance
      send_ray('{HALF, HALF, HALF, 0, -ONE, 0, 0, T_MAX});        // inside, back face
      send_ray('{2 * ONE, HALF, HALF, 0, ONE, 0, T_MIN, T_MAX});  // parallel, outside slab
      send_ray('{ONE, ONE, ONE, 0, 0, 0, T_MIN, T_MAX});          // all parallel, on corner
      send_ray('{-ONE, HALF, HALF, ONE, 0, 0, ONE, ONE});         // empty interval
      send_ray('{-ONE, HALF, HALF, ONE, 0, 0, 5 * ONE, T_MIN});   // inverted interval
      send_ray('{-ONE, HALF, HALF, ONE, 0, 0, 0, HALF});          // hit beyond upper end
      send_ray('{T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX, T_MIN, T_MAX});
      send_ray('{T_MAX, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN, T_MIN, T_MAX});
      send_ray('{T_MIN, HALF, HALF, 1, 0, 0, T_MIN, T_MAX});      // saturated distance
      send_ray('{T_MAX, T_MIN, T_MAX, T_MIN, T_MAX, -1, T_MIN, T_MAX});
      send_ray('{-ONE, -ONE, -ONE, ONE, ONE, ONE, T_MIN, T_MAX}); // through corner
      send_ray('{-ONE, HALF, HALF, ONE, 3, 7, -ONE, T_MAX});
      send_ray('{HALF, HALF, HALF, ONE, ONE, 0, -ONE, T_MAX});
      drain();
      random_rays(250, 1);

      load_box(-3 * ONE, -ONE, -2 * ONE, 5 * HALF, 2 * ONE, HALF, 1000);
      random_rays(250, 0);

      // widest box, widest tolerance
      load_box(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX, 65535);
      send_ray('{0, 0, 0, 0, 0, 0, T_MIN, T_MAX});
      send_ray('{T_MIN, 0, 0, ONE, 0, 0, T_MIN, T_MAX});
      random_rays(240, 0);

      // inverted box with no tolerance, so no face matches
      load_box(ONE, 2 * ONE, ONE, -ONE, 0, -2 * ONE, 0);
      random_rays(250, 0);

      // flat box
      load_box(HALF, 0, 0, HALF, ONE, ONE, 200);
      send_ray('{HALF, HALF, HALF, 0, ONE, 0, T_MIN, T_MAX});
      random_rays(250, 0);

      for (int k = 0; k < 2; k++) begin
         longint lx, ly, lz;
         lx = -longint'($urandom_range(0, 32'h80000));
         ly = -longint'($urandom_range(0, 32'h80000));
         lz = -longint'($urandom_range(0, 32'h80000));
         load_box(lx, ly, lz, lx + $urandom_range(1, 32'h100000),
                  ly + $urandom_range(1, 32'h100000), lz + $urandom_range(1, 32'h100000),
                  $urandom_range(0, 65535));
         random_rays(250, 0);
      end

      if (sb.errors == 0 && sb.hits_due.size() == 0)
         $display("ray_box_slab_intersect test passed");
      else
         $display("ray_box_slab_intersect test failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/rbs_pkg.sv
rtl/core/rbs_if.sv
rtl/core/rbs_div_pipe.sv
rtl/core/ray_box_slab_intersect.sv
verif/tb_ray_box_slab_intersect.sv
